// ----- sv/assert_macros.svh -----
// Assertion macros for the latency matcher.
// Expects aclk and aresetn in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define IOLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that a condition is followed in the next cycle by another
`define IOLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/iolm_pkg.sv -----
// Types and constants shared by the latency matcher modules.
// No dependencies.
package iolm_pkg;

    localparam int ACTION_W    = 16;
    localparam int SECTOR_W    = 64;
    localparam int TIME_W      = 64;
    localparam int LAT_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_CNT_W   = 7;
    localparam int CFG_INDEX_W = 1;

    localparam logic [LAT_W-1:0]    LAT_MAX           = '1;
    localparam logic [ACTION_W-1:0] ISSUE_CODE_RST    = 16'd7;
    localparam logic [ACTION_W-1:0] COMPLETE_CODE_RST = 16'd8;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ISSUE_CODE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPLETE_CODE = 1'b1;

    typedef enum logic {
        KIND_ISSUE,
        KIND_COMPLETE
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [SECTOR_W-1:0] sector;
        logic [TIME_W-1:0]   event_time;
    } q_item_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [TIME_W-1:0]   issue_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_EMIT
    } bk_state_t;

endpackage

// ----- sv/iolm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iolm_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/iolm_front.sv -----
// Front end: classifies trace events and queues issues and completions.
// Depends on iolm_pkg.
module iolm_front import iolm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action_code,
    input  logic [SECTOR_W-1:0] s_sector,
    input  logic [TIME_W-1:0]   s_event_time,
    input  logic [ACTION_W-1:0] issue_code,
    input  logic [ACTION_W-1:0] complete_code,
    output logic                q_valid,
    input  logic                q_ready,
    output q_item_t             q_item
);

    q_item_t    buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       is_complete, is_issue, push, pop;
    q_item_t    in_item;

    assign is_complete = (s_action_code == complete_code);
    assign is_issue    = !is_complete && (s_action_code == issue_code);

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = buf_reg[rd_ptr_reg];

    assign push = s_valid && s_ready && (is_complete || is_issue);
    assign pop  = q_valid && q_ready;

    always_comb begin
        in_item.kind       = is_complete ? KIND_COMPLETE : KIND_ISSUE;
        in_item.sector     = s_sector;
        in_item.event_time = s_event_time;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- sv/iolm_back.sv -----
// Back end: table sequencer (store, youngest-first scan, shift-down) and result register.
// Depends on iolm_pkg and iolm_ram.
module iolm_back import iolm_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    localparam int AW         = $clog2(TABLE_DEPTH),
    localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  q_item_t              q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [LAT_W-1:0]     m_latency_ns,
    output logic [OUT_CNT_W-1:0] m_outstanding,
    output logic [CW-1:0]        count
);

    bk_state_t            state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        idx_reg, idx_next;
    q_item_t              item_reg, item_next;
    status_t              res_reg, res_next;
    logic [LAT_W-1:0]     lat_reg, lat_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg;
    logic [LAT_W-1:0]     m_lat_reg;
    logic [OUT_CNT_W-1:0] m_out_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    entry_t               ram_wdata, ram_rdata;
    logic                 out_free, emit_load;
    logic [TIME_W-1:0]    diff;
    logic [LAT_W-1:0]     lat_calc;

    iolm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign diff     = item_reg.event_time - ram_rdata.issue_time;

    always_comb begin
        if (item_reg.event_time < ram_rdata.issue_time) begin
            lat_calc = '0;
        end else if (diff[TIME_W-1:LAT_W] != '0) begin
            lat_calc = LAT_MAX;
        end else begin
            lat_calc = diff[LAT_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        lat_next   = lat_reg;
        q_ready    = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = idx_reg;
        emit_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next = q_item;
                    lat_next  = '0;
                    unique case (q_item.kind)
                        KIND_COMPLETE: begin
                            if (count_reg == '0) begin
                                res_next   = STATUS_NOT_FOUND;
                                state_next = ST_EMIT;
                            end else begin
                                idx_next   = AW'(count_reg - CW'(1));
                                state_next = ST_SCAN_RD;
                            end
                        end
                        KIND_ISSUE: begin
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                res_next   = STATUS_FULL;
                                state_next = ST_EMIT;
                            end else begin
                                ram_we               = 1'b1;
                                ram_waddr            = count_reg[AW-1:0];
                                ram_wdata.sector     = q_item.sector;
                                ram_wdata.issue_time = q_item.event_time;
                                count_next           = count_reg + CW'(1);
                            end
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (ram_rdata.sector == item_reg.sector) begin
                    res_next = STATUS_OK;
                    lat_next = lat_calc;
                    if (CW'(idx_reg) + CW'(1) == count_reg) begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_SHIFT_RD;
                    end
                end else if (idx_reg == '0) begin
                    res_next   = STATUS_NOT_FOUND;
                    state_next = ST_EMIT;
                end else begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: begin
                ram_raddr  = idx_reg + AW'(1);
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                ram_we = 1'b1;
                if (CW'(idx_reg) + CW'(2) == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_EMIT;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit_load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = emit_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        res_reg  <= res_next;
        lat_reg  <= lat_next;
        if (emit_load) begin
            m_status_reg <= res_reg;
            m_lat_reg    <= lat_reg;
            m_out_reg    <= OUT_CNT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_latency_ns  = m_lat_reg;
    assign m_outstanding = m_out_reg;
    assign count         = count_reg;

endmodule

// ----- sv/io_issue_complete_latency_matcher_core.sv -----
// Top level of the I/O issue/complete latency matcher.
// Depends on iolm_pkg, iolm_front, iolm_back, iolm_ram and assert_macros.svh.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | s_action_code, s_sector, s_event_time
//  m_      | out       | m_valid / m_ready   | m_status, m_latency_ns, m_outstanding
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Ignored actions: taken by the front end and dropped, no table access.
// Issue: one table write in the idle state; table full goes through the emit state to post.
// Completion: taken in idle, a read and a compare state per entry scanned youngest-first,
//   a read and a write state per younger entry shifted down, then the emit state posts.
// Reset is synchronous; the table needs no clearing pass, the count marks live entries.
// A two-entry queue lets the front end keep accepting while the back end stalls.
`include "assert_macros.svh"

module io_issue_complete_latency_matcher_core import iolm_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [ACTION_W-1:0]    s_action_code,
    input  logic [SECTOR_W-1:0]    s_sector,
    input  logic [TIME_W-1:0]      s_event_time,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_W-1:0]    m_status,
    output logic [LAT_W-1:0]       m_latency_ns,
    output logic [OUT_CNT_W-1:0]   m_outstanding,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ACTION_W-1:0]    cfg_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [ACTION_W-1:0] issue_code_reg, issue_code_next;
    logic [ACTION_W-1:0] complete_code_reg, complete_code_next;
    logic                q_valid, q_ready;
    q_item_t             q_item;
    logic [CW-1:0]       bk_count;

    assign cfg_ready = 1'b1;

    always_comb begin
        issue_code_next    = issue_code_reg;
        complete_code_next = complete_code_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_ISSUE_CODE) begin
                issue_code_next = cfg_data;
            end
            if (cfg_index == CFG_COMPLETE_CODE) begin
                complete_code_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_code_reg    <= ISSUE_CODE_RST;
            complete_code_reg <= COMPLETE_CODE_RST;
        end else begin
            issue_code_reg    <= issue_code_next;
            complete_code_reg <= complete_code_next;
        end
    end

    iolm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action_code (s_action_code),
        .s_sector      (s_sector),
        .s_event_time  (s_event_time),
        .issue_code    (issue_code_reg),
        .complete_code (complete_code_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    iolm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_latency_ns  (m_latency_ns),
        .m_outstanding (m_outstanding),
        .count         (bk_count)
    );

    `IOLM_ASSERT(a_count_bound, (bk_count <= CW'(TABLE_DEPTH)), "table count beyond depth")
    `IOLM_ASSERT(a_lat_zero,
        (m_valid && (m_status != STATUS_OK)) |-> (m_latency_ns == '0),
        "latency set on failed result")
    `IOLM_ASSERT(a_queue_full, (!s_ready) |-> q_valid, "input stalled with empty queue")
    `IOLM_ASSERT_NEXT(a_issue_store,
        q_valid && q_ready && (q_item.kind == KIND_ISSUE) && (bk_count != CW'(TABLE_DEPTH)),
        bk_count == $past(bk_count) + CW'(1),
        "issue not stored")

endmodule

// ----- tb/tb_io_issue_complete_latency_matcher_core.sv -----
`timescale 1ns / 100ps
// Testbench for io_issue_complete_latency_matcher_core: a short stimulus table, an overfill
// and half drain, then random trace events under several action-code settings, each result
// checked against a local table. Depends on iolm_pkg and the core RTL only.
module tb_io_issue_complete_latency_matcher_core;
    import iolm_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 20000;
    localparam int DIR_ROWS     = 23;

    typedef enum {EV_IGNORED, EV_STORED, EV_REPORTED} ev_outcome_t;

    typedef struct packed {
        status_t              status;
        logic [LAT_W-1:0]     latency;
        logic [OUT_CNT_W-1:0] outstanding;
    } latency_report_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SECTOR_W-1:0] sector;
        logic [TIME_W-1:0]   stamp;
        logic                known;
        latency_report_t     report;
    } stim_row_t;

    localparam logic [ACTION_W-1:0] ISS = ISSUE_CODE_RST;
    localparam logic [ACTION_W-1:0] CMP = COMPLETE_CODE_RST;
    localparam latency_report_t NO_REPORT = '0;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [ACTION_W-1:0]    s_action_code = '0;
    logic [SECTOR_W-1:0]    s_sector = '0;
    logic [TIME_W-1:0]      s_event_time = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STATUS_W-1:0]    m_status;
    logic [LAT_W-1:0]       m_latency_ns;
    logic [OUT_CNT_W-1:0]   m_outstanding;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ACTION_W-1:0]    cfg_data = '0;

    entry_t              open_requests[$];
    latency_report_t     pending_reports[$];
    logic [ACTION_W-1:0] issue_code = ISSUE_CODE_RST;
    logic [ACTION_W-1:0] complete_code = COMPLETE_CODE_RST;
    logic [TIME_W-1:0]   clock_ns = '0;
    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    bit                  no_idle = 1'b0;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{CMP, 64'd0, 64'd0, 1'b1, '{STATUS_NOT_FOUND, 32'd0, 7'd0}},
        '{16'h0000, 64'd1, 64'd1, 1'b0, NO_REPORT},
        '{16'hffff, 64'd2, 64'd2, 1'b0, NO_REPORT},
        '{ISS, 64'd0, 64'd0, 1'b0, NO_REPORT},
        '{ISS, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0, NO_REPORT},
        '{CMP, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1,
          '{STATUS_OK, 32'd0, 7'd1}},
        '{CMP, 64'd0, 64'h0000_0000_ffff_ffff, 1'b1, '{STATUS_OK, LAT_MAX, 7'd0}},
        '{ISS, 64'd5, 64'd100, 1'b0, NO_REPORT},
        '{CMP, 64'd5, 64'd50, 1'b1, '{STATUS_OK, 32'd0, 7'd0}},
        '{ISS, 64'd9, 64'd0, 1'b0, NO_REPORT},
        '{CMP, 64'd9, 64'h0000_0001_0000_0000, 1'b1, '{STATUS_OK, LAT_MAX, 7'd0}},
        '{ISS, 64'd3, 64'd10, 1'b0, NO_REPORT},
        '{ISS, 64'd4, 64'd20, 1'b0, NO_REPORT},
        '{ISS, 64'd3, 64'd30, 1'b0, NO_REPORT},
        '{CMP, 64'd3, 64'd35, 1'b1, '{STATUS_OK, 32'd5, 7'd2}},
        '{CMP, 64'd6, 64'd40, 1'b1, '{STATUS_NOT_FOUND, 32'd0, 7'd2}},
        '{ISS, 64'h8000_0000_0000_0000, 64'haaaa_5555_aaaa_5555, 1'b0, NO_REPORT},
        '{CMP, 64'd3, 64'd100, 1'b0, NO_REPORT},
        '{CMP, 64'd4, 64'd19, 1'b0, NO_REPORT},
        '{CMP, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 1'b0, NO_REPORT},
        '{ISS, 64'h5555_aaaa_5555_aaaa, 64'h5555_aaaa_5555_aaaa, 1'b0, NO_REPORT},
        '{CMP, 64'haaaa_5555_aaaa_5555, 64'd0, 1'b0, NO_REPORT},
        '{CMP, 64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555, 1'b0, NO_REPORT}
    };

    io_issue_complete_latency_matcher_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action_code(s_action_code),
        .s_sector     (s_sector),
        .s_event_time (s_event_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_latency_ns (m_latency_ns),
        .m_outstanding(m_outstanding),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic ev_outcome_t match_event(input logic [ACTION_W-1:0] act,
                                                input logic [SECTOR_W-1:0] sec,
                                                input logic [TIME_W-1:0] now,
                                                output latency_report_t rep);
        logic [TIME_W-1:0] diff;
        logic              found;
        int                k;
        rep = '0;
        found = 1'b0;
        if (act == complete_code) begin
            rep.status = STATUS_NOT_FOUND;
            // youngest entry wins among duplicate sectors
            for (k = open_requests.size() - 1; k >= 0 && !found; k--) begin
                if (open_requests[k].sector == sec) begin
                    diff = now - open_requests[k].issue_time;
                    if (now < open_requests[k].issue_time) begin
                        rep.latency = '0;
                    end else if (diff[TIME_W-1:LAT_W] != '0) begin
                        rep.latency = LAT_MAX;
                    end else begin
                        rep.latency = diff[LAT_W-1:0];
                    end
                    rep.status = STATUS_OK;
                    open_requests.delete(k);
                    found = 1'b1;
                end
            end
            rep.outstanding = OUT_CNT_W'(open_requests.size());
            return EV_REPORTED;
        end
        if (act == issue_code) begin
            if (open_requests.size() >= TABLE_DEPTH) begin
                rep.status = STATUS_FULL;
                rep.outstanding = OUT_CNT_W'(open_requests.size());
                return EV_REPORTED;
            end
            open_requests.push_back('{sector: sec, issue_time: now});
            return EV_STORED;
        end
        return EV_IGNORED;
    endfunction

    // Starts and ends on a falling edge.
    task automatic send_event(input logic [ACTION_W-1:0] act, input logic [SECTOR_W-1:0] sec,
                              input logic [TIME_W-1:0] stamp, input logic known,
                              input latency_report_t known_rep, output ev_outcome_t outcome);
        latency_report_t rep;
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_action_code = act;
        s_sector = sec;
        s_event_time = stamp;
        do @(posedge aclk); while (!s_ready);
        outcome = match_event(act, sec, stamp, rep);
        if (outcome == EV_REPORTED) begin
            pending_reports.push_back(known ? known_rep : rep);
        end
        @(negedge aclk);
    endtask

    task automatic set_codes(input logic [ACTION_W-1:0] issue, input logic [ACTION_W-1:0] complete);
        s_valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        // let trailing issues finish before the codes change
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = CFG_ISSUE_CODE;
        cfg_data = issue;
        do @(posedge aclk); while (!cfg_ready);
        issue_code = issue;
        @(negedge aclk);
        cfg_index = CFG_COMPLETE_CODE;
        cfg_data = complete;
        do @(posedge aclk); while (!cfg_ready);
        complete_code = complete;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_events(input int count);
        logic [ACTION_W-1:0] act;
        logic [SECTOR_W-1:0] sec;
        logic [TIME_W-1:0]   stamp;
        ev_outcome_t         outcome;
        int                  done;
        int                  burst;
        int                  pick;
        int                  n_open;
        int                  issue_pct;
        done = 0;
        burst = 0;
        while (done < count) begin
            n_open = open_requests.size();
            clock_ns += $urandom_range(0, 1000);
            issue_pct = (n_open < 8) ? 65 : (n_open > 48) ? 25 : 50;
            // now and then fill the table past its depth
            if (burst == 0 && $urandom_range(0, 199) == 0) begin
                burst = TABLE_DEPTH + 4;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                act = ACTION_W'($urandom);
            end else if (burst > 0 || pick < issue_pct) begin
                act = issue_code;
                if (burst > 0) begin
                    burst--;
                end
            end else begin
                act = complete_code;
            end
            pick = $urandom_range(0, 99);
            if (act == complete_code && n_open > 0 && pick < 70) begin
                sec = open_requests[$urandom_range(0, n_open - 1)].sector;
            end else if (pick < 85) begin
                sec = SECTOR_W'($urandom_range(0, 15));
            end else begin
                sec = {$urandom, $urandom};
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                stamp = {$urandom, $urandom};
            end else if (pick < 7) begin
                stamp = clock_ns + {32'd1, $urandom};
            end else begin
                stamp = clock_ns;
            end
            send_event(act, sec, stamp, 1'b0, NO_REPORT, outcome);
            if (outcome != EV_IGNORED) begin
                done++;
            end
        end
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(negedge aclk) begin
        m_ready = aresetn && (no_idle || $urandom_range(0, 99) >= 10);
    end

    always @(posedge aclk) begin
        latency_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h",
                         $time, m_status, m_latency_ns, m_outstanding);
            end else begin
                want = pending_reports.pop_front();
                if (m_status !== want.status) begin
                    note_mismatch("status", 64'(want.status), 64'(m_status));
                end
                if (m_latency_ns !== want.latency) begin
                    note_mismatch("latency_ns", 64'(want.latency), 64'(m_latency_ns));
                end
                if (m_outstanding !== want.outstanding) begin
                    note_mismatch("outstanding", 64'(want.outstanding), 64'(m_outstanding));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        ev_outcome_t         outcome;
        logic [ACTION_W-1:0] code;
        int                  i;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            send_event(dir_rows[i].action, dir_rows[i].sector, dir_rows[i].stamp,
                       dir_rows[i].known, dir_rows[i].report, outcome);
        end

        // overfill, then drain half
        for (i = 0; i < TABLE_DEPTH + 2; i++) begin
            clock_ns += $urandom_range(1, 50);
            send_event(issue_code, SECTOR_W'($urandom_range(0, 31)), clock_ns, 1'b0, NO_REPORT,
                       outcome);
        end
        for (i = 0; i < TABLE_DEPTH / 2; i++) begin
            clock_ns += $urandom_range(1, 50);
            send_event(complete_code, open_requests[$urandom_range(0, open_requests.size() - 1)]
                       .sector, clock_ns, 1'b0, NO_REPORT, outcome);
        end

        code = ACTION_W'($urandom);
        set_codes(code, code);
        random_events(40);

        set_codes(16'h0000, 16'hffff);
        random_events(250);

        no_idle = 1'b1;
        set_codes(16'hffff, 16'h0000);
        random_events(250);
        no_idle = 1'b0;

        repeat (2) begin
            code = ACTION_W'($urandom);
            set_codes(code, code ^ (ACTION_W'(1) << $urandom_range(0, ACTION_W - 1)));
            random_events(250);
        end

        set_codes(ISSUE_CODE_RST, COMPLETE_CODE_RST);
        random_events(50);

        s_valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/iolm_pkg.sv
sv/iolm_ram.sv
sv/iolm_front.sv
sv/iolm_back.sv
sv/io_issue_complete_latency_matcher_core.sv
tb/tb_io_issue_complete_latency_matcher_core.sv
